>>> design/palette_pixel_block_scaler_core_defines.svh
// Assertion macros for the palette pixel block scaler.
`ifndef PALETTE_PIXEL_BLOCK_SCALER_CORE_DEFINES_SVH
`define PALETTE_PIXEL_BLOCK_SCALER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PPBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ppbs_pkg.sv
// Shared widths, register indexes and interface structs of the block scaler.
package ppbs_pkg;

  localparam int SRC_W   = 12;
  localparam int SCALE_W = 4;
  localparam int OFF_W   = 13;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 16;
  localparam int DEST_W  = 9;
  localparam int CFG_IDX_W = 2;
  // signed working width for display coordinates
  localparam int CW      = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd2;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;  // already saturated to 1..MAX_SCALE
    logic signed [OFF_W-1:0]  off_x;
    logic signed [OFF_W-1:0]  off_y;
  } ppbs_geom_t;

  typedef struct packed {
    logic             start;
    logic [SRC_W-1:0] src_x;
    logic [SRC_W-1:0] src_y;
  } ppbs_job_t;

  typedef struct packed {
    logic              valid;
    logic [DEST_W-1:0] x;
    logic [DEST_W-1:0] y;
    logic              last;
  } ppbs_emit_t;

endpackage

>>> design/ppbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/ppbs_mac.sv
// Shared multiply-add unit: offset + coordinate * scale.
module ppbs_mac (
  input  logic [ppbs_pkg::SRC_W-1:0]          coord,
  input  logic [ppbs_pkg::SCALE_W-1:0]        scale,
  input  logic signed [ppbs_pkg::OFF_W-1:0]   offset,
  output logic signed [ppbs_pkg::CW-1:0]      sum
);

  localparam int PW = ppbs_pkg::SRC_W + ppbs_pkg::SCALE_W;

  logic [PW-1:0] prod;

  assign prod = PW'(coord) * PW'(scale);
  assign sum  = ppbs_pkg::CW'(offset) + $signed({{(ppbs_pkg::CW-PW){1'b0}}, prod});

endmodule

>>> design/ppbs_seq.sv
// Block sequencer: corner computation, clipping and raster walk of the block.
module ppbs_seq #(
  parameter int DISPLAY_W = 466,
  parameter int DISPLAY_H = 466
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppbs_pkg::ppbs_geom_t geom,
  input  ppbs_pkg::ppbs_job_t  job,
  input  logic                 emit_take,
  output logic                 ready,
  output ppbs_pkg::ppbs_emit_t emit
);

  localparam int CW = ppbs_pkg::CW;
  localparam logic signed [CW-1:0] LIM_X = CW'(DISPLAY_W);
  localparam logic signed [CW-1:0] LIM_Y = CW'(DISPLAY_H);
  localparam logic signed [CW-1:0] ONE   = CW'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULX = 3'd1;
  localparam logic [2:0] ST_MULY = 3'd2;
  localparam logic [2:0] ST_CLIP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [ppbs_pkg::SRC_W-1:0] sx_r, sy_r;
  logic signed [CW-1:0] bx_r, by_r, x_r, y_r, xe_r, ye_r;

  logic [ppbs_pkg::SRC_W-1:0]        mac_coord;
  logic signed [ppbs_pkg::OFF_W-1:0] mac_off;
  logic signed [CW-1:0]              mac_sum;

  logic signed [CW-1:0] s_ext, xl, yl, xe_c, ys_c, ye_c;
  logic                 drop;
  logic                 row_end, blk_end;

  // one unit serves both axes, x first
  assign mac_coord = (state_r == ST_MULX) ? sx_r : sy_r;
  assign mac_off   = (state_r == ST_MULX) ? geom.off_x : geom.off_y;

  ppbs_mac u_mac (
    .coord  (mac_coord),
    .scale  (geom.scale),
    .offset (mac_off),
    .sum    (mac_sum)
  );

  // visible rectangle of the block; left overhang drops the whole pixel
  assign s_ext = $signed({{(CW-ppbs_pkg::SCALE_W){1'b0}}, geom.scale});
  assign xl    = bx_r + s_ext - ONE;
  assign yl    = by_r + s_ext - ONE;
  assign drop  = (bx_r < 0) || (bx_r >= LIM_X) || (by_r >= LIM_Y) || (yl < 0);
  assign xe_c  = (xl >= LIM_X) ? LIM_X - ONE : xl;
  assign ys_c  = (by_r < 0) ? '0 : by_r;
  assign ye_c  = (yl >= LIM_Y) ? LIM_Y - ONE : yl;

  assign row_end = (x_r == xe_r);
  assign blk_end = row_end && (y_r == ye_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job.start) begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_CLIP;
      ST_CLIP: state_nxt = drop ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        if (emit_take && blk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job.start) begin
      sx_r <= job.src_x;
      sy_r <= job.src_y;
    end
    if (state_r == ST_MULX) begin
      bx_r <= mac_sum;
    end
    if (state_r == ST_MULY) begin
      by_r <= mac_sum;
    end
    if (state_r == ST_CLIP) begin
      x_r  <= bx_r;
      y_r  <= ys_c;
      xe_r <= xe_c;
      ye_r <= ye_c;
    end
    if (state_r == ST_EMIT && emit_take) begin
      if (row_end) begin
        x_r <= bx_r;
        y_r <= y_r + ONE;
      end else begin
        x_r <= x_r + ONE;
      end
    end
  end

  assign ready      = (state_r == ST_IDLE);
  assign emit.valid = (state_r == ST_EMIT);
  assign emit.x     = x_r[ppbs_pkg::DEST_W-1:0];
  assign emit.y     = y_r[ppbs_pkg::DEST_W-1:0];
  assign emit.last  = blk_end;

endmodule

>>> design/palette_pixel_block_scaler_core.sv
// Top level: nearest-neighbour block upscaler with palette lookup.
//
// Input channel (in_valid/in_ready) takes one word per item. A palette
// write (in_func = 0) stores in_entry_color. A pixel (in_func = 1) is
// looked up in the palette and expanded into the visible part of a
// scale-by-scale block of writes, row by row, left to right.
// Keyed transparent pixels and pixels whose block starts left of column 0
// give no writes. A pixel occupies the sequencer for two passes through
// the shared multiply-add unit, a clip step, then its visible writes
// (at most 64 at scale 8), one per cycle unless the output stalls.
// in_ready is high only while the sequencer is idle.
// The output register holds a word until out_ready; a stall freezes the
// raster walk, and the next item may be taken while the last word waits.
// out_block_last marks the final write of a pixel.
// Reset (rst_n low, synchronous) sets scale 1, offsets 0 and empties the
// output; palette contents are undefined until written.
`include "palette_pixel_block_scaler_core_defines.svh"

module palette_pixel_block_scaler_core #(
  parameter int DISPLAY_W    = 466,
  parameter int DISPLAY_H    = 466,
  parameter int MAX_SCALE    = 8,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_we,
  input  logic [ppbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppbs_pkg::OFF_W-1:0]         cfg_wdata,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [ppbs_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic [ppbs_pkg::COLOR_W-1:0]       in_entry_color,
  input  logic [ppbs_pkg::SRC_W-1:0]         in_src_x,
  input  logic [ppbs_pkg::SRC_W-1:0]         in_src_y,
  input  logic                               in_keying_on,
  input  logic [ppbs_pkg::IDX_W-1:0]         in_key_index,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ppbs_pkg::DEST_W-1:0]        out_dest_x,
  output logic [ppbs_pkg::DEST_W-1:0]        out_dest_y,
  output logic [ppbs_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                               out_block_last
);

  localparam int AW = $clog2(PALETTE_SIZE);
  localparam logic [ppbs_pkg::IDX_W:0] PAL_LIM = (ppbs_pkg::IDX_W + 1)'(PALETTE_SIZE);
  localparam logic [ppbs_pkg::SCALE_W-1:0] SCALE_MAX = ppbs_pkg::SCALE_W'(MAX_SCALE);

  logic [ppbs_pkg::SCALE_W-1:0]       scale_r;
  logic signed [ppbs_pkg::OFF_W-1:0]  off_x_r, off_y_r;

  logic                               accept, idx_ok, keyed;
  logic                               pal_we, pal_re;
  logic [ppbs_pkg::COLOR_W-1:0]       pal_rdata;
  logic                               oob_r;

  ppbs_pkg::ppbs_geom_t               geom;
  ppbs_pkg::ppbs_job_t                job;
  ppbs_pkg::ppbs_emit_t               emit;
  logic                               emit_take;
  logic                               seq_ready;

  logic                               out_valid_r;
  logic [ppbs_pkg::DEST_W-1:0]        out_x_r, out_y_r;
  logic [ppbs_pkg::COLOR_W-1:0]       out_color_r;
  logic                               out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ppbs_pkg::SCALE_W'(1);
      off_x_r <= '0;
      off_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppbs_pkg::CFG_SCALE:    scale_r <= cfg_wdata[ppbs_pkg::SCALE_W-1:0];
        ppbs_pkg::CFG_OFFSET_X: off_x_r <= cfg_wdata;
        ppbs_pkg::CFG_OFFSET_Y: off_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero scale acts as 1, oversize saturates
  always_comb begin
    geom.off_x = off_x_r;
    geom.off_y = off_y_r;
    if (scale_r == '0) begin
      geom.scale = ppbs_pkg::SCALE_W'(1);
    end else if (scale_r > SCALE_MAX) begin
      geom.scale = SCALE_MAX;
    end else begin
      geom.scale = scale_r;
    end
  end

  assign in_ready = seq_ready;
  assign accept   = in_valid && in_ready;
  assign idx_ok   = ({1'b0, in_pixel_index} < PAL_LIM);
  assign keyed    = in_keying_on && (in_pixel_index == in_key_index);
  assign pal_we   = accept && !in_func && idx_ok;
  assign pal_re   = accept && in_func;

  ppbs_ram #(
    .WIDTH (ppbs_pkg::COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_pixel_index[AW-1:0]),
    .wdata (in_entry_color),
    .re    (pal_re),
    .raddr (in_pixel_index[AW-1:0]),
    .rdata (pal_rdata)
  );

  // index past the palette reads as black
  always_ff @(posedge clk) begin
    if (pal_re) begin
      oob_r <= !idx_ok;
    end
  end

  assign job.start = accept && in_func && !keyed;
  assign job.src_x = in_src_x;
  assign job.src_y = in_src_y;

  ppbs_seq #(
    .DISPLAY_W (DISPLAY_W),
    .DISPLAY_H (DISPLAY_H)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .job       (job),
    .emit_take (emit_take),
    .ready     (seq_ready),
    .emit      (emit)
  );

  // output register; loads whenever empty or being drained
  assign emit_take = emit.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_x_r     <= emit.x;
      out_y_r     <= emit.y;
      out_color_r <= oob_r ? '0 : pal_rdata;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dest_x      = out_x_r;
  assign out_dest_y      = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_block_last  = out_last_r;

  `PPBS_ASSERT_NEXT(a_busy_after_start, job.start, !in_ready, "ready high after pixel start")
  `PPBS_ASSERT_NEXT(a_idle_after_last, emit_take && emit.last, in_ready, "not idle after last word")
  `PPBS_ASSERT_NEXT(a_pal_write_one_cycle, accept && !in_func, in_ready, "palette write left block busy")
  `PPBS_ASSERT_NOW(a_take_needs_room, emit_take, !out_valid_r || out_ready, "output word overwritten")

endmodule
